// ===== hdl/ufm_pkg.sv =====
`default_nettype none

package ufm_pkg;

  localparam int NODE_COUNT = 1024;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int END_W      = 10;
  localparam int COST_W     = 16;
  localparam int SUM_W      = 26;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [SUM_W-1:0]  SUM_LIMIT  = '1;
  localparam logic [NODE_W-1:0] SWEEP_LAST = NODE_W'(NODE_COUNT - 1);

  // Command word as classified by the front end
  typedef struct packed {
    logic              is_clear;
    logic              in_range;
    logic [END_W-1:0]  end_a;
    logic [END_W-1:0]  end_b;
    logic [COST_W-1:0] cost;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic             taken;
    logic [SUM_W-1:0] total;
    logic             done;
  } res_t;

  typedef enum logic [1:0] {
    BK_SWEEP,
    BK_IDLE,
    BK_WALK_A,
    BK_WALK_B
  } back_state_t;

endpackage

`default_nettype wire

// ===== hdl/ufm_front.sv =====
`default_nettype none

module ufm_front import ufm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              in_command,
  input  wire logic [END_W-1:0]  in_end_a,
  input  wire logic [END_W-1:0]  in_end_b,
  input  wire logic [COST_W-1:0] in_edge_cost,
  input  wire logic              in_final_edge,
  output logic                   head_valid,
  output cmd_t                   head,
  input  wire logic              head_pop
);

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;
  cmd_t              cls;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = head_pop && head_valid;

  // Classify the transaction before it is queued
  always_comb begin
    cls.is_clear = !in_command;
    cls.in_range = (int'(in_end_a) < NODE_COUNT) && (int'(in_end_b) < NODE_COUNT);
    cls.end_a    = in_end_a;
    cls.end_b    = in_end_b;
    cls.cost     = in_edge_cost;
    cls.last     = in_final_edge;
  end

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ufm_back.sv =====
`default_nettype none

module ufm_back import ufm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic head_valid,
  input  wire cmd_t head,
  output logic      head_pop,
  input  wire logic slot_free,
  output logic      res_valid,
  output res_t      res
);

  back_state_t       state_r, state_nxt;
  logic [NODE_W-1:0] tbl [NODE_COUNT];
  logic [NODE_W-1:0] rd_data_r;
  logic [NODE_W-1:0] cur_r, cur_nxt;
  logic [NODE_W-1:0] root_a_r, root_a_nxt;
  logic [NODE_W-1:0] sweep_r, sweep_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SUM_W:0]    sum_add;
  logic              tbl_we;
  logic [NODE_W-1:0] tbl_wa;
  logic [NODE_W-1:0] tbl_wd;
  logic              at_root;

  assign at_root = (rd_data_r == cur_r);
  assign sum_add = {1'b0, sum_r} + (SUM_W + 1)'(head.cost);

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    root_a_nxt = root_a_r;
    sweep_nxt  = sweep_r;
    sum_nxt    = sum_r;
    tbl_we     = 1'b0;
    tbl_wa     = sweep_r;
    tbl_wd     = sweep_r;
    head_pop   = 1'b0;
    res_valid  = 1'b0;
    res.taken  = 1'b0;
    res.total  = sum_r;
    res.done   = head.last;
    case (state_r)
      BK_SWEEP: begin
        tbl_we    = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == SWEEP_LAST) begin
          sweep_nxt = '0;
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (head_valid) begin
          if (head.is_clear) begin
            if (slot_free) begin
              res_valid = 1'b1;
              res.total = '0;
              res.done  = 1'b0;
              head_pop  = 1'b1;
              sum_nxt   = '0;
              state_nxt = BK_SWEEP;
            end
          end else if (!head.in_range) begin
            if (slot_free) begin
              res_valid = 1'b1;
              head_pop  = 1'b1;
            end
          end else begin
            cur_nxt   = head.end_a[NODE_W-1:0];
            state_nxt = BK_WALK_A;
          end
        end
      end
      BK_WALK_A: begin
        if (at_root) begin
          root_a_nxt = cur_r;
          cur_nxt    = head.end_b[NODE_W-1:0];
          state_nxt  = BK_WALK_B;
        end else begin
          cur_nxt = rd_data_r;
        end
      end
      BK_WALK_B: begin
        if (!at_root) begin
          cur_nxt = rd_data_r;
        end else if (slot_free) begin
          // Link root of end_b under root of end_a
          if (cur_r != root_a_r) begin
            tbl_we    = 1'b1;
            tbl_wa    = cur_r;
            tbl_wd    = root_a_r;
            res.taken = 1'b1;
            sum_nxt   = (sum_add >= {1'b0, SUM_LIMIT}) ? SUM_LIMIT : sum_add[SUM_W-1:0];
            res.total = sum_nxt;
          end
          res_valid = 1'b1;
          head_pop  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_SWEEP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_SWEEP;
      sweep_r <= '0;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    root_a_r <= root_a_nxt;
  end

  // Parent table: one write port, one registered read port following the walk
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl[tbl_wa] <= tbl_wd;
    end
    rd_data_r <= tbl[cur_nxt];
  end

`ifndef SYNTHESIS
  a_walk_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_WALK_A || state_r == BK_WALK_B) |-> head_valid)
    else $error("walk without a queued command");

  a_pop_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |-> (head_valid && res_valid))
    else $error("command retired without a result");

  a_result_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> slot_free)
    else $error("result issued while output register busy");

  a_write_when_allowed: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |-> (state_r == BK_SWEEP || (state_r == BK_WALK_B && res.taken)))
    else $error("unexpected parent table write");

  a_clear_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && head.is_clear) |=> (state_r == BK_SWEEP && sweep_r == '0 && sum_r == '0))
    else $error("clear did not start a sweep");
`endif

endmodule

`default_nettype wire

// ===== hdl/union_find_mst_cost_unit.sv =====
`default_nettype none

// Kruskal spanning-forest cost engine. Push edges (command=1) in non-decreasing
// cost order; each gets one result with edge_taken, the saturating running total
// and run_done echoing final_edge. command=0 clears the forest and total and
// answers with an all-zero result. An edge's time in the back end is set by the
// parent-pointer walks from end_a and end_b through the single read port of the
// 1024-entry parent table (one hop per cycle); an edge with an endpoint out of
// range retires without a walk. A clear, and reset, rebuild the table in a sweep
// of all 1024 entries, one entry per cycle, during which queued edges wait. A
// two-entry command queue lets the input side keep accepting while the back end
// works, and an output register holds a result until it is popped.
module union_find_mst_cost_unit import ufm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              in_command,
  input  wire logic [END_W-1:0]  in_end_a,
  input  wire logic [END_W-1:0]  in_end_b,
  input  wire logic [COST_W-1:0] in_edge_cost,
  input  wire logic              in_final_edge,
  output logic                   empty,
  input  wire logic              pop,
  output logic                   out_edge_taken,
  output logic [SUM_W-1:0]       out_total_cost,
  output logic                   out_run_done
);

  logic head_valid;
  cmd_t head;
  logic head_pop;
  logic slot_free;
  logic res_valid;
  res_t res;
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  ufm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_command   (in_command),
    .in_end_a     (in_end_a),
    .in_end_b     (in_end_b),
    .in_edge_cost (in_edge_cost),
    .in_final_edge(in_final_edge),
    .head_valid   (head_valid),
    .head         (head),
    .head_pop     (head_pop)
  );

  ufm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head      (head),
    .head_pop  (head_pop),
    .slot_free (slot_free),
    .res_valid (res_valid),
    .res       (res)
  );

  // Free the output register when it is empty or popped this cycle
  assign slot_free = !out_valid_r || pop;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign empty          = !out_valid_r;
  assign out_edge_taken = out_res_r.taken;
  assign out_total_cost = out_res_r.total;
  assign out_run_done   = out_res_r.done;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none

module tb_top;
  import ufm_pkg::*;

  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_EDGE  = 1'b1;

  localparam int POP_ALWAYS = 0;
  localparam int POP_HALF   = 1;
  localparam int POP_RARE   = 2;
  localparam int POP_BURSTY = 3;

  localparam int RANDOM_ITEMS = 1200;
  localparam int IDLE_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 2100;

  // Forest model: parent pointers, saturating cost total, queue of pending results
  class mst_scoreboard;
    logic [NODE_W-1:0] parent [NODE_COUNT];
    logic [SUM_W-1:0]  cost_total;
    res_t              expected_q[$];
    int unsigned       errors;

    function new();
      errors = 0;
      clear_forest();
    endfunction

    function void clear_forest();
      foreach (parent[v]) parent[v] = NODE_W'(v);
      cost_total = '0;
    endfunction

    function logic [NODE_W-1:0] root_of(logic [NODE_W-1:0] v);
      logic [NODE_W-1:0] node;
      node = v;
      for (int hop = 0; hop < NODE_COUNT; hop++) begin
        if (parent[node] == node) break;
        node = parent[node];
      end
      return node;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function void note_input(logic cmd, logic [END_W-1:0] a, logic [END_W-1:0] b,
                             logic [COST_W-1:0] cost, logic last);
      res_t              res;
      logic [NODE_W-1:0] root_a;
      logic [NODE_W-1:0] root_b;
      res = '0;
      if (cmd == CMD_CLEAR) begin
        clear_forest();
        expected_q.push_back(res);
        return;
      end
      if (int'(a) < NODE_COUNT && int'(b) < NODE_COUNT) begin
        root_a = root_of(NODE_W'(a));
        root_b = root_of(NODE_W'(b));
        if (root_a != root_b) begin
          parent[root_b] = root_a;
          res.taken = 1'b1;
          if (SUM_W'(cost) >= SUM_LIMIT - cost_total) cost_total = SUM_LIMIT;
          else cost_total = cost_total + SUM_W'(cost);
        end
      end
      res.total = cost_total;
      res.done  = last;
      expected_q.push_back(res);
    endfunction

    task check_result(logic taken, logic [SUM_W-1:0] total, logic done);
      res_t exp_res;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing pending: taken=%0b total=%0d done=%0b",
                         taken, total, done));
        return;
      end
      exp_res = expected_q.pop_front();
      if (taken !== exp_res.taken)
        report($sformatf("edge_taken %0b, predicted %0b", taken, exp_res.taken));
      if (total !== exp_res.total)
        report($sformatf("total_cost %0d, predicted %0d", total, exp_res.total));
      if (done !== exp_res.done)
        report($sformatf("run_done %0b, predicted %0b", done, exp_res.done));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic              in_command = 1'b0;
  logic [END_W-1:0]  in_end_a = '0;
  logic [END_W-1:0]  in_end_b = '0;
  logic [COST_W-1:0] in_edge_cost = '0;
  logic              in_final_edge = 1'b0;
  logic              empty;
  logic              pop = 1'b0;
  logic              out_edge_taken;
  logic [SUM_W-1:0]  out_total_cost;
  logic              out_run_done;

  mst_scoreboard sb = new();

  int burst_left = 0;
  int stall_mode = POP_ALWAYS;
  int stall_left = 0;
  int pop_phase = 0;
  int idle_cycles = 0;

  union_find_mst_cost_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_command    (in_command),
    .in_end_a      (in_end_a),
    .in_end_b      (in_end_b),
    .in_edge_cost  (in_edge_cost),
    .in_final_edge (in_final_edge),
    .empty         (empty),
    .pop           (pop),
    .out_edge_taken(out_edge_taken),
    .out_total_cost(out_total_cost),
    .out_run_done  (out_run_done)
  );

  always #5 clk = ~clk;

  task automatic send(logic cmd, logic [END_W-1:0] a, logic [END_W-1:0] b,
                      logic [COST_W-1:0] cost, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    push          <= 1'b1;
    in_command    <= cmd;
    in_end_a      <= a;
    in_end_b      <= b;
    in_edge_cost  <= cost;
    in_final_edge <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_input(cmd, a, b, cost, last);
    burst_left--;
  endtask

  task automatic send_clear();
    // endpoints, cost and final flag are don't-care on a clear; keep them random
    send(CMD_CLEAR, END_W'($urandom), END_W'($urandom), COST_W'($urandom), 1'($urandom));
  endtask

  task automatic send_edge(int a, int b, int cost, logic last);
    send(CMD_EDGE, END_W'(a), END_W'(b), COST_W'(cost), last);
  endtask

  // One well-formed graph: clear, then edges in non-decreasing cost, final flag on the last
  task automatic send_graph(inout int sent);
    int span;
    int base;
    int n_edges;
    int cost;
    span = ($urandom_range(0, 9) == 0) ? NODE_COUNT : $urandom_range(2, 48);
    base = $urandom_range(0, NODE_COUNT - span);
    n_edges = $urandom_range(1, (2 * span > 40) ? 40 : 2 * span);
    cost = ($urandom_range(0, 3) == 0) ? $urandom_range(60000, 65535) : $urandom_range(0, 65535);
    send_clear();
    sent++;
    for (int i = 0; i < n_edges; i++) begin
      cost = cost + $urandom_range(0, 1500);
      if (cost > 65535) cost = 65535;
      send_edge(base + $urandom_range(0, span - 1), base + $urandom_range(0, span - 1),
                cost, i == n_edges - 1);
      sent++;
    end
  endtask

  task automatic send_noise(inout int sent);
    int n_items;
    n_items = $urandom_range(1, 6);
    for (int i = 0; i < n_items; i++) begin
      send(($urandom_range(0, 7) == 0) ? CMD_CLEAR : CMD_EDGE, END_W'($urandom),
           END_W'($urandom), COST_W'($urandom), 1'($urandom));
      sent++;
    end
  endtask

  // Result side: check, then pick the next pop value from the current stall pattern
  always @(posedge clk) begin
    if (rst_n && pop && !empty) sb.check_result(out_edge_taken, out_total_cost, out_run_done);
    if (stall_left == 0) begin
      stall_mode = $urandom_range(POP_ALWAYS, POP_BURSTY);
      stall_left = $urandom_range(16, 200);
    end else begin
      stall_left--;
    end
    pop_phase++;
    case (stall_mode)
      POP_ALWAYS: pop <= 1'b1;
      POP_HALF:   pop <= 1'($urandom_range(0, 1));
      POP_RARE:   pop <= ($urandom_range(0, 7) == 0);
      default:    pop <= ((pop_phase % 6) < 2);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int sent;
    sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, clear with junk fields, repeat edge, self loop, deep chain
    send_clear();
    send_edge(0, 1023, 0, 1'b0);
    send_edge(1023, 0, 0, 1'b0);
    send_edge(5, 5, 3, 1'b0);
    for (int v = 100; v < 110; v++) send_edge(v + 1, v, 100 + v, 1'b0);
    send_edge(100, 1023, 400, 1'b0);
    send_edge(100, 110, 500, 1'b0);
    send_edge(682, 341, 65535, 1'b1);
    // unsorted: lower cost after the maximum
    send_edge(200, 201, 10, 1'b0);
    send_edge(201, 1023, 65535, 1'b1);
    send_clear();
    send_edge(1023, 1022, 65535, 1'b1);

    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 8) send_graph(sent);
      else send_noise(sent);
    end
    push <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
